// ----- rtl/core/length_prefixed_record_fifo_defines.svh -----
// Assertion macros shared by the record FIFO RTL.
// Users must have clk and rst in scope; no other dependencies.
`ifndef LENGTH_PREFIXED_RECORD_FIFO_DEFINES_SVH
`define LENGTH_PREFIXED_RECORD_FIFO_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define LPRF_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("record fifo check failed");

// Next-cycle implication, disabled while in reset.
`define LPRF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("record fifo check failed");

`endif

// ----- rtl/core/lprf_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the
// record FIFO. No dependencies.
`timescale 1ns / 1ps

package lprf_pkg;

  localparam int QUEUE_BYTES  = 1024;
  localparam int MAX_RECORD   = 64;
  localparam int HEADER_BYTES = 4;

  localparam int PTR_W  = $clog2(QUEUE_BYTES);
  localparam int FREE_W = $clog2(QUEUE_BYTES + 1);
  localparam int SUM_W  = FREE_W + 7;
  localparam int HCNT_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam int ACC_W  = 8 * HEADER_BYTES;
  localparam int LEN_W  = 7;
  localparam int CNT_W  = 7;

  typedef enum logic [2:0] {
    OP_BEGIN_PUT = 3'd0,
    OP_PUT_BYTE  = 3'd1,
    OP_TAKE      = 3'd2,
    OP_PEEK      = 3'd3,
    OP_CLEAR     = 3'd4
  } lprf_op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_SEQ_ERR  = 2'd3
  } lprf_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_HDR_WR,
    S_HDR_RD,
    S_HDR_ACC,
    S_CALC,
    S_STREAM_REQ,
    S_STREAM_DATA,
    S_RESP
  } lprf_state_t;

  typedef struct packed {
    logic         capture;
    logic         reserve;
    logic         hdr_write;
    logic         put_write;
    logic         clear_q;
    logic         rdp_load;
    logic         rd_issue;
    logic         hdr_acc;
    logic         calc;
    logic         set_status;
    lprf_status_t status_code;
    logic         out_single;
    logic         out_byte;
  } lprf_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       pbl_zero;
    logic       len_bad;
    logic       queue_empty;
    logic       hcnt_last;
    logic       count_zero;
    logic       cnt_one;
    logic       out_free;
  } lprf_stat_t;

endpackage

// ----- rtl/core/lprf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lprf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/lprf_datapath.sv -----
// Datapath of the record FIFO: byte store, pointers, space accounting,
// header assembly and the result register. Depends on lprf_pkg and lprf_ram.
`timescale 1ns / 1ps

module lprf_datapath (
  input  logic               clk,
  input  logic               rst,
  input  lprf_pkg::lprf_cmd_t  cmd,
  output lprf_pkg::lprf_stat_t st,
  input  logic [2:0]         opcode,
  input  logic [6:0]         length,
  input  logic [7:0]         data_byte,
  input  logic               res_stall,
  output logic               res_valid,
  output logic [1:0]         status,
  output logic [7:0]         data_byte_res,
  output logic               byte_valid,
  output logic               last
);

  import lprf_pkg::*;

  logic [2:0]        op_q;
  logic [LEN_W-1:0]  len_q;
  logic [7:0]        byte_q;
  logic [PTR_W-1:0]  rp;
  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  rdp;
  logic [FREE_W-1:0] free_bytes;
  logic [LEN_W-1:0]  pbl;
  logic [HCNT_W-1:0] hcnt;
  logic [ACC_W-1:0]  hdr_acc;
  logic [CNT_W-1:0]  cnt;
  lprf_status_t      resp_code;

  logic              ram_we;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  logic [SUM_W-1:0]  need;
  logic [LEN_W-1:0]  stored_sat;
  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  span;
  logic [SUM_W-1:0]  rp_sum;
  logic [SUM_W-1:0]  free_sum;
  logic [PTR_W-1:0]  rp_adv;
  logic [FREE_W-1:0] free_add;
  logic              is_take;

  function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_BYTES - 1)) ? '0 : p + 1'b1;
  endfunction

  lprf_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (ram_wdata),
    .re    (cmd.rd_issue),
    .raddr (rdp),
    .rdata (ram_rdata)
  );

  // The header carries the length least significant byte first; a length
  // fits in the first byte, so the rest are zero.
  assign ram_we    = cmd.hdr_write || cmd.put_write;
  assign ram_wdata = cmd.hdr_write ? ((hcnt == '0) ? {1'b0, len_q} : 8'h00) : byte_q;

  always_comb begin
    need       = SUM_W'(len_q) + SUM_W'(HEADER_BYTES);
    stored_sat = (hdr_acc > ACC_W'(MAX_RECORD)) ? LEN_W'(MAX_RECORD)
                                                : hdr_acc[LEN_W-1:0];
    count      = (len_q < stored_sat) ? len_q : stored_sat;
    span       = SUM_W'(stored_sat) + SUM_W'(HEADER_BYTES);
    rp_sum     = SUM_W'(rp) + span;
    free_sum   = SUM_W'(free_bytes) + span;
    rp_adv     = (rp_sum >= SUM_W'(QUEUE_BYTES)) ? PTR_W'(rp_sum - SUM_W'(QUEUE_BYTES))
                                                 : rp_sum[PTR_W-1:0];
    free_add   = (free_sum > SUM_W'(QUEUE_BYTES)) ? FREE_W'(QUEUE_BYTES)
                                                  : free_sum[FREE_W-1:0];
    is_take    = (op_q == OP_TAKE);
  end

  assign st.op          = op_q;
  assign st.pbl_zero    = (pbl == '0);
  assign st.len_bad     = (len_q > LEN_W'(MAX_RECORD)) || (SUM_W'(free_bytes) < need);
  assign st.queue_empty = (free_bytes >= FREE_W'(QUEUE_BYTES));
  assign st.hcnt_last   = (hcnt == HCNT_W'(HEADER_BYTES - 1));
  assign st.count_zero  = (count == '0);
  assign st.cnt_one     = (cnt == CNT_W'(1));
  assign st.out_free    = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= opcode;
      len_q  <= length;
      byte_q <= data_byte;
    end
    if (cmd.capture) begin
      hcnt <= '0;
    end else if (cmd.hdr_write || cmd.hdr_acc) begin
      hcnt <= hcnt + 1'b1;
    end
    if (cmd.hdr_acc) begin
      for (int i = 0; i < HEADER_BYTES; i++) begin
        if (hcnt == HCNT_W'(i)) begin
          hdr_acc[8*i +: 8] <= ram_rdata;
        end
      end
    end
    if (cmd.rdp_load) begin
      rdp <= rp;
    end else if (cmd.rd_issue) begin
      rdp <= next_pos(rdp);
    end
    if (cmd.calc) begin
      cnt <= count;
    end else if (cmd.out_byte) begin
      cnt <= cnt - 1'b1;
    end
    if (cmd.set_status) begin
      resp_code <= cmd.status_code;
    end
    if (cmd.out_single) begin
      status        <= resp_code;
      data_byte_res <= 8'h00;
      byte_valid    <= 1'b0;
      last          <= 1'b1;
    end else if (cmd.out_byte) begin
      status        <= ST_OK;
      data_byte_res <= ram_rdata;
      byte_valid    <= 1'b1;
      last          <= st.cnt_one;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp         <= '0;
      wp         <= '0;
      free_bytes <= FREE_W'(QUEUE_BYTES);
      pbl        <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (ram_we) begin
        wp <= next_pos(wp);
      end
      if (cmd.clear_q) begin
        rp <= wp;
      end else if (cmd.calc && is_take) begin
        rp <= rp_adv;
      end
      if (cmd.clear_q) begin
        free_bytes <= FREE_W'(QUEUE_BYTES);
      end else if (cmd.reserve) begin
        free_bytes <= free_bytes - need[FREE_W-1:0];
      end else if (cmd.calc && is_take) begin
        free_bytes <= free_add;
      end
      if (cmd.clear_q) begin
        pbl <= '0;
      end else if (cmd.reserve) begin
        pbl <= len_q;
      end else if (cmd.put_write) begin
        pbl <= pbl - 1'b1;
      end
      if (cmd.out_single || cmd.out_byte) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/lprf_ctrl.sv -----
// Controller state machine of the record FIFO: sequences each request over
// the datapath. Depends on lprf_pkg.
`timescale 1ns / 1ps

module lprf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  lprf_pkg::lprf_stat_t st,
  output lprf_pkg::lprf_cmd_t  cmd
);

  import lprf_pkg::*;

  lprf_state_t state;
  lprf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd_stall  = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.set_status  = 1'b1;
        cmd.status_code = ST_OK;
        state_next      = S_RESP;
        unique case (st.op)
          OP_BEGIN_PUT: begin
            priority if (!st.pbl_zero) begin
              cmd.status_code = ST_SEQ_ERR;
            end else if (st.len_bad) begin
              cmd.status_code = ST_NO_SPACE;
            end else begin
              cmd.reserve = 1'b1;
              state_next  = S_HDR_WR;
            end
          end
          OP_PUT_BYTE: begin
            if (st.pbl_zero) begin
              cmd.status_code = ST_SEQ_ERR;
            end else begin
              cmd.put_write = 1'b1;
            end
          end
          OP_TAKE, OP_PEEK: begin
            priority if (!st.pbl_zero) begin
              cmd.status_code = ST_SEQ_ERR;
            end else if (st.queue_empty) begin
              cmd.status_code = ST_EMPTY;
            end else begin
              cmd.rdp_load = 1'b1;
              state_next   = S_HDR_RD;
            end
          end
          OP_CLEAR: begin
            cmd.clear_q = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_HDR_WR: begin
        cmd.hdr_write = 1'b1;
        if (st.hcnt_last) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_OK;
          state_next      = S_RESP;
        end
      end
      S_HDR_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_HDR_ACC;
      end
      S_HDR_ACC: begin
        cmd.hdr_acc = 1'b1;
        state_next  = st.hcnt_last ? S_CALC : S_HDR_RD;
      end
      S_CALC: begin
        // A take frees the record here; streaming reads from its own pointer.
        cmd.calc = 1'b1;
        if (st.count_zero) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_OK;
          state_next      = S_RESP;
        end else begin
          state_next = S_STREAM_REQ;
        end
      end
      S_STREAM_REQ: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_STREAM_DATA;
      end
      S_STREAM_DATA: begin
        // The read register holds its byte until the result register frees up.
        if (st.out_free) begin
          cmd.out_byte = 1'b1;
          if (st.cnt_one) begin
            state_next = S_IDLE;
          end else begin
            cmd.rd_issue = 1'b1;
          end
        end
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.out_single = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/length_prefixed_record_fifo.sv -----
// Channel   Direction  Handshake            Payload
// cmd       in         cmd_valid/cmd_stall  opcode, length, data_byte
// res       out        res_valid/res_stall  status, data_byte_res, byte_valid, last
//
// One request is handled at a time; the controller holds cmd_stall high from
// acceptance until the request's last result is loaded into the result register.
// Header bytes of a take/peek are read through the single read port of the byte
// store, each read issued and then accumulated before the next; record bytes then
// stream one per cycle while the result register is not stalled. res_stall holds
// the result register and the controller states that load it. Reset is synchronous;
// the byte store needs no clearing pass.
//
// Top level of the record FIFO. Depends on lprf_pkg, lprf_ctrl, lprf_datapath
// and the assertion macro header.
`timescale 1ns / 1ps
`include "length_prefixed_record_fifo_defines.svh"

module length_prefixed_record_fifo (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [2:0] opcode,
  input  logic [6:0] length,
  input  logic [7:0] data_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [1:0] status,
  output logic [7:0] data_byte_res,
  output logic       byte_valid,
  output logic       last
);

  import lprf_pkg::*;

  lprf_cmd_t  cmd;
  lprf_stat_t st;

  lprf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .st        (st),
    .cmd       (cmd)
  );

  lprf_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .opcode        (opcode),
    .length        (length),
    .data_byte     (data_byte),
    .res_stall     (res_stall),
    .res_valid     (res_valid),
    .status        (status),
    .data_byte_res (data_byte_res),
    .byte_valid    (byte_valid),
    .last          (last)
  );

  `LPRF_ASSERT_IMPLIES(a_load_only_when_free, (cmd.out_byte || cmd.out_single), st.out_free)
  `LPRF_ASSERT_IMPLIES(a_no_store_rw_overlap, (cmd.hdr_write || cmd.put_write), !cmd.rd_issue)
  `LPRF_ASSERT_IMPLIES(a_no_byte_result_is_last, (res_valid && !byte_valid), last)
  `LPRF_ASSERT_NEXT(a_busy_after_request, (cmd_valid && !cmd_stall), cmd_stall)

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for length_prefixed_record_fifo: directed and random requests
// with a shadow copy of the record queue that predicts every result.
// Depends on lprf_pkg and the record FIFO RTL.
`timescale 1ns / 1ps

module tb;
  import lprf_pkg::*;

  localparam int IDLE_CYCLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES    = 2 * (5 + 2 * HEADER_BYTES + MAX_RECORD);
  localparam int PRINT_LIMIT      = 40;

  typedef struct packed {
    lprf_status_t code;
    logic [7:0]   data;
    logic         valid;
    logic         last;
  } fifo_result_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic       cmd_stall;
  logic [2:0] opcode = '0;
  logic [6:0] length = '0;
  logic [7:0] data_byte = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [1:0] status;
  logic [7:0] data_byte_res;
  logic       byte_valid;
  logic       last;

  wire cmd_fire = cmd_valid && !cmd_stall;
  wire res_fire = res_valid && !res_stall;

  // Shadow copy of the record queue.
  logic [7:0]        ring_mem [QUEUE_BYTES];
  logic [PTR_W-1:0]  ring_rd = '0;
  logic [PTR_W-1:0]  ring_wr = '0;
  logic [FREE_W-1:0] ring_free = FREE_W'(QUEUE_BYTES);
  logic [6:0]        put_remaining = '0;

  fifo_result_t due_results[$];

  bit cmd_idle_en = 1'b1;
  bit res_idle_en = 1'b1;
  int request_count = 0;
  int result_count = 0;
  int streamed_bytes = 0;
  int no_space_count = 0;
  int seq_err_count = 0;
  int empty_count = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  int res_stall_left = 0;

  length_prefixed_record_fifo u_dut (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .opcode       (opcode),
    .length       (length),
    .data_byte    (data_byte),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .status       (status),
    .data_byte_res(data_byte_res),
    .byte_valid   (byte_valid),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [PTR_W-1:0] next_slot(logic [PTR_W-1:0] slot);
    return (slot == PTR_W'(QUEUE_BYTES - 1)) ? '0 : slot + 1'b1;
  endfunction

  task automatic push_single(lprf_status_t code);
    due_results.push_back('{code, 8'h00, 1'b0, 1'b1});
  endtask

  // Applies one accepted request to the shadow queue and queues its results.
  task automatic apply_request(logic [2:0] op, logic [6:0] len, logic [7:0] dat);
    int unsigned stored;
    int unsigned count;
    int unsigned freed;
    logic [PTR_W-1:0] pos;
    case (op)
      OP_BEGIN_PUT: begin
        if (put_remaining != 0) begin
          push_single(ST_SEQ_ERR);
        end else if (len > MAX_RECORD || ring_free < len + HEADER_BYTES) begin
          push_single(ST_NO_SPACE);
        end else begin
          // The header is little-endian; a 7-bit length fits in its first byte.
          for (int i = 0; i < HEADER_BYTES; i++) begin
            ring_mem[ring_wr] = (i == 0) ? 8'(len) : 8'h00;
            ring_wr = next_slot(ring_wr);
          end
          ring_free -= FREE_W'(len + HEADER_BYTES);
          put_remaining = len;
          push_single(ST_OK);
        end
      end
      OP_PUT_BYTE: begin
        if (put_remaining == 0) begin
          push_single(ST_SEQ_ERR);
        end else begin
          ring_mem[ring_wr] = dat;
          ring_wr = next_slot(ring_wr);
          put_remaining -= 1'b1;
          push_single(ST_OK);
        end
      end
      OP_TAKE, OP_PEEK: begin
        if (put_remaining != 0) begin
          push_single(ST_SEQ_ERR);
        end else if (ring_free >= QUEUE_BYTES) begin
          push_single(ST_EMPTY);
        end else begin
          stored = 0;
          pos = ring_rd;
          for (int i = 0; i < HEADER_BYTES; i++) begin
            if (i < 4) stored |= 32'(ring_mem[pos]) << (8 * i);
            pos = next_slot(pos);
          end
          if (stored > MAX_RECORD) stored = MAX_RECORD;
          count = (len < stored) ? len : stored;
          if (count == 0) begin
            push_single(ST_OK);
          end else begin
            for (int unsigned i = 0; i < count; i++) begin
              due_results.push_back('{ST_OK, ring_mem[pos], 1'b1, i + 1 == count});
              pos = next_slot(pos);
            end
          end
          if (op == OP_TAKE) begin
            freed = stored + HEADER_BYTES;
            ring_rd = PTR_W'((ring_rd + freed) % QUEUE_BYTES);
            ring_free = (ring_free + freed > QUEUE_BYTES) ? FREE_W'(QUEUE_BYTES)
                                                          : FREE_W'(ring_free + freed);
          end
        end
      end
      OP_CLEAR: begin
        ring_rd = ring_wr;
        ring_free = FREE_W'(QUEUE_BYTES);
        put_remaining = '0;
        push_single(ST_OK);
      end
      default: push_single(ST_OK);
    endcase
  endtask

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Drives one request, waits for its acceptance and predicts its results.
  task automatic send_request(logic [2:0] op, int len = 0, int dat = 0);
    if (cmd_idle_en && $urandom_range(0, 4) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    opcode    <= op;
    length    <= 7'(len);
    data_byte <= 8'(dat);
    do @(posedge clk); while (cmd_stall !== 1'b0);
    apply_request(op, 7'(len), 8'(dat));
    request_count++;
  endtask

  // Holds off new requests until every predicted result has come back.
  task automatic wait_for_drain();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  // begin_put followed by the record's bytes; may cut in with a stray request.
  task automatic write_record(int len, bit may_break);
    send_request(OP_BEGIN_PUT, len);
    if (put_remaining != len) return;
    for (int k = 0; k < len; k++) begin
      if (may_break && $urandom_range(0, 29) == 0) begin
        case ($urandom_range(0, 3))
          0: send_request(OP_TAKE, $urandom_range(0, 64));
          1: send_request(OP_PEEK, $urandom_range(0, 64));
          2: send_request(OP_BEGIN_PUT, $urandom_range(0, 64));
          default: begin
            send_request(OP_CLEAR);
            return;
          end
        endcase
      end
      send_request(OP_PUT_BYTE, 0, $urandom_range(0, 255));
    end
  endtask

  task automatic test_empty_queue();
    send_request(OP_TAKE, 10);
    send_request(OP_PEEK, 10);
    send_request(OP_PUT_BYTE, 0, 8'h3C);
    for (int code = int'(OP_CLEAR) + 1; code < (1 << $bits(opcode)); code++) begin
      send_request(3'(code), 127, 255);
    end
    wait_for_drain();
  endtask

  task automatic test_zero_length_record();
    write_record(0, 1'b0);
    send_request(OP_PEEK, 9);
    send_request(OP_TAKE, 0);
    send_request(OP_TAKE, 5);
    wait_for_drain();
  endtask

  task automatic test_put_sequence();
    send_request(OP_BEGIN_PUT, 127);
    send_request(OP_BEGIN_PUT, MAX_RECORD + 1);
    send_request(OP_BEGIN_PUT, 3);
    send_request(OP_BEGIN_PUT, 1);
    send_request(OP_TAKE, 8);
    send_request(OP_PEEK, 8);
    send_request(OP_PUT_BYTE, 0, 8'h00);
    send_request(OP_PUT_BYTE, 0, 8'hFF);
    send_request(OP_PUT_BYTE, 0, 8'h5A);
    send_request(OP_PUT_BYTE, 0, 8'h01);
    send_request(OP_PEEK, MAX_RECORD);
    send_request(OP_PEEK, 2);
    send_request(OP_TAKE, 1);
    wait_for_drain();
  endtask

  task automatic test_clear_during_put();
    send_request(OP_BEGIN_PUT, MAX_RECORD);
    send_request(OP_PUT_BYTE, 0, 8'hA5);
    send_request(OP_PUT_BYTE, 0, 8'h96);
    send_request(OP_CLEAR);
    send_request(OP_PEEK, 4);
    send_request(OP_CLEAR);
    wait_for_drain();
  endtask

  task automatic test_random_traffic(int num_requests);
    int first;
    int pick;
    first = request_count;
    while (request_count - first < num_requests) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        write_record(($urandom_range(0, 4) == 0) ? $urandom_range(17, MAX_RECORD)
                                                 : $urandom_range(0, 16), 1'b1);
      end else if (pick < 72) begin
        send_request(OP_TAKE, ($urandom_range(0, 7) == 0) ? $urandom_range(65, 127)
                                                          : $urandom_range(0, 64));
      end else if (pick < 85) begin
        send_request(OP_PEEK, $urandom_range(0, 127));
      end else if (pick < 89) begin
        send_request(OP_CLEAR);
      end else begin
        case ($urandom_range(0, 2))
          0: send_request(OP_PUT_BYTE, 0, $urandom_range(0, 255));
          1: send_request(OP_BEGIN_PUT, $urandom_range(MAX_RECORD + 1, 127));
          default: send_request(3'($urandom_range(int'(OP_CLEAR) + 1,
                                                  (1 << $bits(opcode)) - 1)),
                                $urandom_range(0, 127), $urandom_range(0, 255));
        endcase
      end
      if ($urandom_range(0, 39) == 0) wait_for_drain();
    end
  endtask

  // Result-side stalls come in bursts of random length.
  always @(posedge clk) begin
    if (res_stall_left != 0) begin
      res_stall_left--;
      res_stall <= 1'b1;
    end else if (!rst && res_idle_en && $urandom_range(0, 5) == 0) begin
      res_stall_left = $urandom_range(1, 5) - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    fifo_result_t want;
    if (!rst && res_fire === 1'b1) begin
      result_count++;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result with none expected: status %0d byte %02h",
                                  status, data_byte_res));
      end else begin
        want = due_results.pop_front();
        if (status !== want.code)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.code));
        if (data_byte_res !== want.data)
          report_mismatch($sformatf("data_byte_res %02h, expected %02h",
                                    data_byte_res, want.data));
        if (byte_valid !== want.valid)
          report_mismatch($sformatf("byte_valid %b, expected %b", byte_valid, want.valid));
        if (last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", last, want.last));
        if (want.valid) streamed_bytes++;
        case (want.code)
          ST_NO_SPACE: no_space_count++;
          ST_SEQ_ERR:  seq_err_count++;
          ST_EMPTY:    empty_count++;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cmd_fire === 1'b1 || res_fire === 1'b1) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_CYCLE_LIMIT) begin
        $display("Timeout: no request or result accepted for %0d cycles", idle_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_zero_length_record();
    test_put_sequence();
    test_clear_during_put();
    test_random_traffic(110);
    // The last stretch runs at full rate on both sides.
    cmd_idle_en = 1'b0;
    res_idle_en = 1'b0;
    test_random_traffic(30);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", due_results.size()));
    $display("Ran %0d requests with %0d results and %0d record bytes streamed,",
             request_count, result_count, streamed_bytes);
    $display("including %0d no-space, %0d sequence-error and %0d empty answers.",
             no_space_count, seq_err_count, empty_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
